### design/signed_int_to_decimal_ascii_assert.svh
// Assertion macros used by the checker file of the decimal text converter.
// No dependencies; pulled in by `include.
`ifndef SIGNED_INT_TO_DECIMAL_ASCII_ASSERT_SVH
`define SIGNED_INT_TO_DECIMAL_ASCII_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted.
`define SITDA_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define SITDA_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

### design/sitda_pkg.sv
// Types and constants for the signed integer to decimal text converter.
// No dependencies.
package sitda_pkg;

  localparam int unsigned MagWidth      = 32;
  localparam int unsigned NumDigits     = 10;
  localparam int unsigned BcdWidth      = 4 * NumDigits;
  localparam int unsigned NumStages     = 4;
  localparam int unsigned StepsPerStage = MagWidth / NumStages;
  localparam int unsigned IdxWidth      = $clog2(NumDigits);

  localparam logic [7:0] CharZero  = 8'd48;
  localparam logic [7:0] CharMinus = 8'd45;

  // One word moving down the double-dabble pipeline.
  typedef struct packed {
    logic                neg;
    logic [MagWidth-1:0] bin;
    logic [BcdWidth-1:0] bcd;
  } dd_word_t;

endpackage

### design/sitda_if.sv
// Valid/ready channel interfaces for the decimal text converter.
// No dependencies.
interface sitda_in_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] value;

  modport source (output valid, output value, input ready);
  modport sink (input valid, input value, output ready);
endinterface

interface sitda_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] character;
  logic       last_char;

  modport source (output valid, output character, output last_char, input ready);
  modport sink (input valid, input character, input last_char, output ready);
endinterface

### design/sitda_dd_stage.sv
// One register stage of the double-dabble binary to BCD pipeline.
// Depends on sitda_pkg.
module sitda_dd_stage (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               valid_i,
  output logic               ready_o,
  input  sitda_pkg::dd_word_t word_i,
  output logic               valid_o,
  input  logic               ready_i,
  output sitda_pkg::dd_word_t word_o
);
  import sitda_pkg::*;

  logic     valid_q;
  dd_word_t word_q;

  // Shift-and-add-3 over this stage's share of the binary bits.
  function automatic dd_word_t dabble(dd_word_t w);
    dd_word_t r;
    r = w;
    for (int s = 0; s < StepsPerStage; s++) begin
      for (int d = 0; d < NumDigits; d++) begin
        if (r.bcd[d*4 +: 4] >= 4'd5) begin
          r.bcd[d*4 +: 4] = r.bcd[d*4 +: 4] + 4'd3;
        end
      end
      {r.bcd, r.bin} = {r.bcd, r.bin} << 1;
    end
    return r;
  endfunction

  assign ready_o = !valid_q || ready_i;
  assign valid_o = valid_q;
  assign word_o  = word_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready_o && valid_i) begin
      word_q <= dabble(word_i);
    end
  end

endmodule

### design/sitda_ser.sv
// Serializer: turns one BCD word into a run of ASCII characters.
// Depends on sitda_pkg.
module sitda_ser (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               valid_i,
  output logic               ready_o,
  input  sitda_pkg::dd_word_t word_i,
  output logic               valid_o,
  input  logic               ready_i,
  output logic [7:0]         character_o,
  output logic               last_char_o
);
  import sitda_pkg::*;

  logic                busy_q, busy_d;
  logic                neg_q, neg_d;
  logic [IdxWidth-1:0] idx_q, idx_d;
  logic [BcdWidth-1:0] bcd_q, bcd_d;
  logic                oval_q, oval_d;
  logic [7:0]          ochar_q, ochar_d;
  logic                olast_q, olast_d;

  logic                out_free, emit;
  logic                cur_neg;
  logic [IdxWidth-1:0] cur_idx;
  logic [BcdWidth-1:0] cur_bcd;
  logic [3:0]          digit;

  // Position of the most significant nonzero digit; zero gives position 0.
  function automatic logic [IdxWidth-1:0] top_idx(logic [BcdWidth-1:0] bcd);
    logic [IdxWidth-1:0] idx;
    idx = '0;
    for (int d = 1; d < NumDigits; d++) begin
      if (bcd[d*4 +: 4] != 4'd0) begin
        idx = IdxWidth'(d);
      end
    end
    return idx;
  endfunction

  assign out_free = !oval_q || ready_i;
  assign ready_o  = out_free && !busy_q;
  assign emit     = out_free && (busy_q || valid_i);

  always_comb begin
    cur_neg = busy_q ? neg_q : word_i.neg;
    cur_idx = busy_q ? idx_q : top_idx(word_i.bcd);
    cur_bcd = busy_q ? bcd_q : word_i.bcd;
    digit   = 4'd0;
    for (int d = 0; d < NumDigits; d++) begin
      if (IdxWidth'(d) == cur_idx) begin
        digit = cur_bcd[d*4 +: 4];
      end
    end
  end

  always_comb begin
    busy_d  = busy_q;
    neg_d   = neg_q;
    idx_d   = idx_q;
    bcd_d   = bcd_q;
    oval_d  = oval_q;
    ochar_d = ochar_q;
    olast_d = olast_q;
    if (emit) begin
      oval_d  = 1'b1;
      ochar_d = cur_neg ? CharMinus : CharZero + {4'd0, digit};
      olast_d = !cur_neg && (cur_idx == '0);
      bcd_d   = cur_bcd;
      neg_d   = 1'b0;
      if (cur_neg) begin
        busy_d = 1'b1;
        idx_d  = cur_idx;
      end else if (cur_idx == '0) begin
        busy_d = 1'b0;
      end else begin
        busy_d = 1'b1;
        idx_d  = cur_idx - 1'b1;
      end
    end else if (ready_i) begin
      oval_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      neg_q  <= 1'b0;
      idx_q  <= '0;
      oval_q <= 1'b0;
    end else begin
      busy_q <= busy_d;
      neg_q  <= neg_d;
      idx_q  <= idx_d;
      oval_q <= oval_d;
    end
  end

  always_ff @(posedge clk_i) begin
    bcd_q   <= bcd_d;
    ochar_q <= ochar_d;
    olast_q <= olast_d;
  end

  assign valid_o     = oval_q;
  assign character_o = ochar_q;
  assign last_char_o = olast_q;

endmodule

### design/signed_int_to_decimal_ascii.sv
// Channel   Dir  Word               Meaning
// in_i      in   value[31:0] s      integer to convert
// out_o     out  character[7:0]     '-' or '0'..'9', most significant first
//                last_char          set on the final character of a number
//
// An input register takes the magnitude, four register stages run eight
// double-dabble steps each, and a serializer with an output register sends
// one character per cycle while out ready is high. A number's first character
// goes through the input register, each stage register and the output register.
// Reset clears the valid bits and the serializer state. A low out ready holds
// the output word and backs up through the stages to in ready; nothing is
// dropped or repeated.
module signed_int_to_decimal_ascii (
  input  logic               clk_i,
  input  logic               rst_ni,
  sitda_in_if.sink           in_i,
  sitda_out_if.source        out_o
);
  import sitda_pkg::*;

  logic                abs_valid_q;
  dd_word_t            abs_word_q, abs_word_d;
  logic [MagWidth-1:0] raw;

  logic     st_valid [NumStages+1];
  logic     st_ready [NumStages+1];
  dd_word_t st_word  [NumStages+1];

  assign raw = unsigned'(in_i.value);

  always_comb begin
    abs_word_d.neg = raw[MagWidth-1];
    abs_word_d.bin = raw[MagWidth-1] ? (~raw + 1'b1) : raw;
    abs_word_d.bcd = '0;
  end

  assign in_i.ready = !abs_valid_q || st_ready[0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      abs_valid_q <= 1'b0;
    end else if (in_i.ready) begin
      abs_valid_q <= in_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_i.ready && in_i.valid) begin
      abs_word_q <= abs_word_d;
    end
  end

  assign st_valid[0] = abs_valid_q;
  assign st_word[0]  = abs_word_q;

  for (genvar g = 0; g < NumStages; g++) begin : g_dd
    sitda_dd_stage u_stage (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .valid_i (st_valid[g]),
      .ready_o (st_ready[g]),
      .word_i  (st_word[g]),
      .valid_o (st_valid[g+1]),
      .ready_i (st_ready[g+1]),
      .word_o  (st_word[g+1])
    );
  end

  sitda_ser u_ser (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .valid_i     (st_valid[NumStages]),
    .ready_o     (st_ready[NumStages]),
    .word_i      (st_word[NumStages]),
    .valid_o     (out_o.valid),
    .ready_i     (out_o.ready),
    .character_o (out_o.character),
    .last_char_o (out_o.last_char)
  );

endmodule

### design/sitda_chk.sv
// Port-level checker for the decimal text converter, bound to the top level.
// Depends on signed_int_to_decimal_ascii_assert.svh.
`include "signed_int_to_decimal_ascii_assert.svh"

module sitda_chk (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       out_valid_i,
  input logic       out_ready_i,
  input logic [7:0] out_character_i,
  input logic       out_last_char_i
);

  // Stalled output word holds.
  `SITDA_ASSERT_NEXT(a_out_hold, clk_i, rst_ni, out_valid_i && !out_ready_i, out_valid_i && $stable(out_character_i) && $stable(out_last_char_i), "output word changed under stall")

  `SITDA_ASSERT_NOW(a_char_set, clk_i, rst_ni, out_valid_i, (out_character_i == 8'd45) || ((out_character_i >= 8'd48) && (out_character_i <= 8'd57)), "character is neither sign nor digit")

  `SITDA_ASSERT_NOW(a_sign_not_last, clk_i, rst_ni, out_valid_i && (out_character_i == 8'd45), !out_last_char_i, "sign flagged as last character")

  // Within a run the serializer has the next character ready at once.
  `SITDA_ASSERT_NEXT(a_run_no_gap, clk_i, rst_ni, out_valid_i && out_ready_i && !out_last_char_i, out_valid_i, "gap inside a character run")

endmodule

bind signed_int_to_decimal_ascii sitda_chk u_sitda_chk (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .out_valid_i     (out_o.valid),
  .out_ready_i     (out_o.ready),
  .out_character_i (out_o.character),
  .out_last_char_i (out_o.last_char)
);
